### design/selective_state_scan_assert.svh
// Assertion macros shared by the scan block modules.
`ifndef SELECTIVE_STATE_SCAN_ASSERT_SVH
`define SELECTIVE_STATE_SCAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SSS_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sss assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sss assertion failed");

`endif

### design/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Types, constants and helpers shared by the selective state scan modules.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int CH_W   = 10;
    localparam int ST_W   = 4;
    localparam int Q_W    = 32;
    localparam int CNT_W  = 5;
    localparam int LAST_W = 7;
    localparam int SUM_W  = 50;

    typedef struct packed {
        logic [CH_W-1:0]       channel;
        logic [ST_W-1:0]       state_index;
        logic                  fresh_start;
        logic signed [Q_W-1:0] decay;
        logic signed [Q_W-1:0] drive;
        logic signed [Q_W-1:0] out_coeff;
        logic signed [Q_W-1:0] input_u;
        logic signed [Q_W-1:0] skip_weight;
    } t_elem;

    typedef struct packed {
        logic                  ovf;
        logic signed [Q_W-1:0] val;
    } t_sat;

    // Count the restoring steps needed to reduce a value up to max_v modulo mod_v.
    function automatic int red_steps(input int mod_v, input int max_v);
        int n;
        n = 0;
        for (int k = 0; k < 16; k++) begin
            if ((mod_v << k) <= max_v) n++;
        end
        return n;
    endfunction

    // Clip a wide sum to 32 bits, flagging overflow.
    function automatic t_sat sat32(input logic signed [SUM_W-1:0] v);
        t_sat r;
        if (v > SUM_W'(64'sh7FFF_FFFF)) begin
            r.ovf = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end else if (v < -SUM_W'(64'sh8000_0000)) begin
            r.ovf = 1'b1;
            r.val = 32'sh8000_0000;
        end else begin
            r.ovf = 1'b0;
            r.val = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/sss_ram.sv
// ----------------------------------------------------------------------------
// sss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/sss_front.sv
// ----------------------------------------------------------------------------
// sss_front
// Accept one element word, fold channel and state index into the store range
// and hand the element with its store address to the queue.
// ----------------------------------------------------------------------------
`include "selective_state_scan_assert.svh"
module sss_front #(
    parameter int CHANNELS = 1024,
    parameter int STATES   = 16,
    parameter int AW       = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sss_pkg::t_elem  i_elem,
    input  logic            i_full,
    output logic            o_push,
    output logic [AW-1:0]   o_addr,
    output sss_pkg::t_elem  o_elem
);

    localparam int SC    = sss_pkg::red_steps(CHANNELS, 1023);
    localparam int SS    = sss_pkg::red_steps(STATES, 15);
    localparam int STEPS = (SC > SS) ? SC : SS;

    logic                         r_valid;
    logic [4:0]                   r_cnt;
    sss_pkg::t_elem               r_elem;
    logic [sss_pkg::CH_W-1:0]     r_ch;
    logic [sss_pkg::ST_W-1:0]     r_st;
    logic [3:0]                   w_k;
    logic [23:0]                  w_ch_lim;
    logic [23:0]                  w_st_lim;

    assign w_k      = 4'(r_cnt - 5'd1);
    assign w_ch_lim = 24'(CHANNELS) << w_k;
    assign w_st_lim = 24'(STATES) << w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
                r_cnt   <= 5'(STEPS);
                r_elem  <= i_elem;
                r_ch    <= i_elem.channel;
                r_st    <= i_elem.state_index;
            end else if (r_valid && r_cnt != 5'd0) begin
                // one restoring step per cycle, largest multiple first
                if (32'(w_k) < SC && {14'b0, r_ch} >= w_ch_lim)
                    r_ch <= r_ch - w_ch_lim[sss_pkg::CH_W-1:0];
                if (32'(w_k) < SS && {20'b0, r_st} >= w_st_lim)
                    r_st <= r_st - w_st_lim[sss_pkg::ST_W-1:0];
                r_cnt <= r_cnt - 5'd1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_ready = !r_valid;
    assign o_push  = r_valid && (r_cnt == 5'd0) && !i_full;
    assign o_addr  = AW'(32'(r_ch) * STATES + 32'(r_st));
    assign o_elem  = r_elem;

    `SSS_ASSERT_NEXT(a_front_load, i_clk, i_rst_n, i_valid && o_ready, r_valid)

endmodule

### design/sss_fifo.sv
// ----------------------------------------------------------------------------
// sss_fifo
// Two-entry queue between the front and the back of the scan block.
// ----------------------------------------------------------------------------
`include "selective_state_scan_assert.svh"
module sss_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_buf [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_buf[r_wp] <= i_data;
                r_wp        <= !r_wp;
            end
            if (i_pop) r_rp <= !r_rp;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_data  = r_buf[r_rp];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    `SSS_ASSERT_IMPL(a_fifo_no_overrun, i_clk, i_rst_n, r_count == 2'd2, !i_push)

endmodule

### design/sss_back.sv
// ----------------------------------------------------------------------------
// sss_back
// Read-modify-write of the hidden store, accumulate the channel output and
// drive the output register.
// ----------------------------------------------------------------------------
`include "selective_state_scan_assert.svh"
module sss_back #(
    parameter int CHANNELS = 1024,
    parameter int STATES   = 16,
    parameter int AW       = 14
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  logic [AW-1:0]               i_addr,
    input  sss_pkg::t_elem              i_elem,
    output logic                        o_pop,
    input  logic [sss_pkg::LAST_W-1:0]  i_last_index,
    input  logic                        i_tready,
    output logic                        o_tvalid,
    output logic [sss_pkg::CH_W-1:0]    o_channel,
    output logic [sss_pkg::Q_W-1:0]     o_scan,
    output logic                        o_sat
);

    typedef enum logic [2:0] {S_IDLE, S_MUL1, S_ADD1, S_MUL2, S_ADD2, S_EMIT} t_state;

    t_state                    r_state;
    sss_pkg::t_elem            r_elem;
    logic [AW-1:0]             r_addr;
    logic signed [63:0]        r_p0;
    logic signed [63:0]        r_p1;
    logic signed [63:0]        r_p2;
    logic signed [31:0]        r_h;
    logic signed [31:0]        r_acc0;
    logic                      r_iflag;
    logic signed [31:0]        r_acc;
    logic                      r_flag;
    logic                      r_ovalid;
    logic [sss_pkg::CH_W-1:0]  r_ochan;
    logic [31:0]               r_oscan;
    logic                      r_osat;

    logic [31:0]               w_rdata;
    logic signed [31:0]        w_old;
    logic                      w_st0;
    sss_pkg::t_sat             w_h;
    sss_pkg::t_sat             w_a0;
    sss_pkg::t_sat             w_acc;
    logic signed [31:0]        w_base;
    logic                      w_base_flag;

    assign w_st0 = (r_elem.state_index == '0);
    assign w_old = r_elem.fresh_start ? 32'sd0 : $signed(w_rdata);
    assign w_h   = sss_pkg::sat32(sss_pkg::SUM_W'(r_p1 >>> 16)
                                  + sss_pkg::SUM_W'(r_elem.drive));
    assign w_a0  = sss_pkg::sat32(sss_pkg::SUM_W'(r_p0 >>> 16));
    assign w_base      = w_st0 ? r_acc0 : r_acc;
    assign w_base_flag = w_st0 ? 1'b0 : r_flag;
    assign w_acc = sss_pkg::sat32(sss_pkg::SUM_W'(w_base) + sss_pkg::SUM_W'(r_p2 >>> 16));

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    sss_ram #(
        .WIDTH (32),
        .DEPTH (CHANNELS * STATES),
        .AW    (AW)
    ) u_hidden (
        .i_clk   (i_clk),
        .i_we    (r_state == S_ADD1),
        .i_waddr (r_addr),
        .i_wdata (w_h.val),
        .i_re    (o_pop),
        .i_raddr (i_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= '0;
            r_flag   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // the emit step owns the valid bit while it runs
            if (r_ovalid && i_tready && r_state != S_EMIT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_elem  <= i_elem;
                        r_addr  <= i_addr;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p0    <= 64'(r_elem.skip_weight) * 64'(r_elem.input_u);
                    r_p1    <= 64'(r_elem.decay) * 64'(w_old);
                    r_state <= S_ADD1;
                end
                S_ADD1: begin
                    r_h     <= w_h.val;
                    r_acc0  <= w_a0.val;
                    r_iflag <= w_h.ovf || (w_st0 && w_a0.ovf);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p2    <= 64'(r_h) * 64'(r_elem.out_coeff);
                    r_state <= S_ADD2;
                end
                S_ADD2: begin
                    r_acc  <= w_acc.val;
                    r_flag <= w_base_flag || r_iflag || w_acc.ovf;
                    if (sss_pkg::LAST_W'(r_elem.state_index) == i_last_index)
                        r_state <= S_EMIT;
                    else
                        r_state <= S_IDLE;
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (!r_ovalid || i_tready) begin
                        r_ovalid <= 1'b1;
                        r_ochan  <= r_elem.channel;
                        r_oscan  <= r_acc;
                        r_osat   <= r_flag;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_tvalid  = r_ovalid;
    assign o_channel = r_ochan;
    assign o_scan    = r_oscan;
    assign o_sat     = r_osat;

    `SSS_ASSERT_NEXT(a_back_emit, i_clk, i_rst_n,
        r_state == S_EMIT && (!r_ovalid || i_tready), r_ovalid && r_state == S_IDLE)

endmodule

### design/selective_state_scan.sv
// ----------------------------------------------------------------------------
// selective_state_scan
// Selective state-space scan element processor, signed Q16.16.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis (tdata: channel, state index, decay, drive,
// out_coeff, input_u, skip_weight; tuser: fresh start). Items run channel
// major, states ascending. Each word updates one hidden entry to
// decay*h + drive and adds h*out_coeff to the channel accumulator, which is
// seeded with skip_weight*input_u at state zero. The word whose state index is
// one less than state_count clamped to 1..STATES emits one word on m_axis
// (tdata: channel, scan value; tuser: saturation flag of the run).
// The front holds one word at a time: it runs N restoring steps that fold the
// channel and state index into the store range (0 at the default sizes), then
// hands the word to the queue before it takes the next. The back is a
// read-modify-write of the hidden store through its multiply, add, multiply
// and add states, plus its emit state on a run's last word; it sets the sustained rate.
// state_count is written on the cfg channel, which is always ready.
// Reset clears the control state, the accumulator and the flag; state_count
// returns to 16 and the hidden store holds no defined data. A stalled
// receiver holds the output register; the back then waits in its emit step
// and the queue fills until s_axis_tready drops.
// ----------------------------------------------------------------------------
module selective_state_scan #(
    parameter int CHANNELS = 1024,
    parameter int STATES   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [4:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // channel[9:0], state_index[13:10], decay[45:14], drive[77:46],
    // out_coeff[109:78], input_u[141:110], skip_weight[173:142], zero fill
    input  logic [175:0] s_axis_tdata,
    // fresh_start[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_channel[9:0], scan_out[41:10], zero fill
    output logic [47:0]  m_axis_tdata,
    // saturated[0]
    output logic [0:0]   m_axis_tuser
);

    localparam int DEPTH = CHANNELS * STATES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW    = $bits(sss_pkg::t_elem) + AW;

    logic [sss_pkg::CNT_W-1:0]  r_state_count;
    logic [sss_pkg::LAST_W-1:0] w_cnt;
    logic [sss_pkg::LAST_W-1:0] w_last;
    sss_pkg::t_elem             w_in;
    sss_pkg::t_elem             w_f_elem;
    sss_pkg::t_elem             w_b_elem;
    logic [AW-1:0]              w_f_addr;
    logic [AW-1:0]              w_b_addr;
    logic                       w_push;
    logic                       w_pop;
    logic                       w_full;
    logic                       w_empty;
    logic [QW-1:0]              w_q_out;
    logic [sss_pkg::CH_W-1:0]   w_ochan;
    logic [31:0]                w_oscan;
    logic                       w_osat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_count <= 5'd16;
        end else if (i_cfg_valid) begin
            r_state_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // clamp the count to 1..STATES
    always_comb begin
        w_cnt = sss_pkg::LAST_W'(r_state_count);
        if (w_cnt == '0) w_cnt = sss_pkg::LAST_W'(1);
        if (w_cnt > sss_pkg::LAST_W'(STATES)) w_cnt = sss_pkg::LAST_W'(STATES);
        w_last = w_cnt - sss_pkg::LAST_W'(1);
    end

    assign w_in.channel     = s_axis_tdata[9:0];
    assign w_in.state_index = s_axis_tdata[13:10];
    assign w_in.fresh_start = s_axis_tuser[0];
    assign w_in.decay       = s_axis_tdata[45:14];
    assign w_in.drive       = s_axis_tdata[77:46];
    assign w_in.out_coeff   = s_axis_tdata[109:78];
    assign w_in.input_u     = s_axis_tdata[141:110];
    assign w_in.skip_weight = s_axis_tdata[173:142];

    sss_front #(
        .CHANNELS (CHANNELS),
        .STATES   (STATES),
        .AW       (AW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_elem  (w_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_addr  (w_f_addr),
        .o_elem  (w_f_elem)
    );

    sss_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_addr, w_f_elem}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    assign w_b_addr = w_q_out[QW-1 -: AW];
    assign w_b_elem = w_q_out[$bits(sss_pkg::t_elem)-1:0];

    sss_back #(
        .CHANNELS (CHANNELS),
        .STATES   (STATES),
        .AW       (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_addr       (w_b_addr),
        .i_elem       (w_b_elem),
        .o_pop        (w_pop),
        .i_last_index (w_last),
        .i_tready     (m_axis_tready),
        .o_tvalid     (m_axis_tvalid),
        .o_channel    (w_ochan),
        .o_scan       (w_oscan),
        .o_sat        (w_osat)
    );

    assign m_axis_tdata = {6'b0, w_oscan, w_ochan};
    assign m_axis_tuser = w_osat;

endmodule

### bench/selective_state_scan_tb.sv
// ----------------------------------------------------------------------------
// selective_state_scan_tb
// Self-checking bench for the selective state scan block.
// ----------------------------------------------------------------------------
// A short table of hand-built words is run first, with the state count at one.
// It covers the field extremes, floor rounding, saturation of the seed, the
// hidden value and the sum, and words past the count. Random channel runs with
// well-formed state order follow, mixed with stray words, under several
// counts including 0 and 31. Each accepted word goes through a local
// fixed-point scan model. Output words are checked in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module selective_state_scan_tb;

    typedef struct {
        logic [sss_pkg::CH_W-1:0]       chan;
        logic signed [sss_pkg::Q_W-1:0] val;
        logic                           sat;
    } t_scan_out;

    typedef struct {
        sss_pkg::t_elem                 item;
        logic                           typed;
        logic signed [sss_pkg::Q_W-1:0] val;
        logic                           sat;
    } t_row;

    localparam int N_CH       = 1024;
    localparam int N_ST       = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int RAND_ITEMS = 1000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [4:0]   i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [175:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    selective_state_scan dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // scan model state
    logic signed [sss_pkg::Q_W-1:0] hidden_mem [0:N_CH*N_ST-1];
    bit                             hidden_set [0:N_CH*N_ST-1];
    logic signed [sss_pkg::Q_W-1:0] scan_acc;
    logic                           scan_sat;
    logic [4:0]                     state_cnt;

    t_scan_out scan_due[$];
    int        fail_count;
    int        words_sent;
    int        words_checked;
    int        cycle_count;
    int        stall_left;
    bit        calm;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] q_mul(logic signed [63:0] a,
                                                 logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic logic signed [sss_pkg::Q_W-1:0] clip32(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) begin
            scan_sat = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            scan_sat = 1'b1;
            return 32'sh8000_0000;
        end
        return v[sss_pkg::Q_W-1:0];
    endfunction

    // Advance the scan by one word; report the output word if this one emits.
    function automatic bit scan_word(sss_pkg::t_elem e, output t_scan_out r);
        int                             n;
        int                             idx;
        logic signed [63:0]             prev;
        logic signed [sss_pkg::Q_W-1:0] h;
        n = (state_cnt == 0) ? 1 : (state_cnt > N_ST) ? N_ST : state_cnt;
        idx = e.channel * N_ST + e.state_index;
        if (e.state_index == 0) begin
            scan_sat = 1'b0;
            scan_acc = clip32(q_mul(e.skip_weight, e.input_u));
        end
        prev = e.fresh_start ? 64'sd0 : 64'(hidden_mem[idx]);
        h = clip32(q_mul(e.decay, prev) + 64'(e.drive));
        hidden_mem[idx] = h;
        hidden_set[idx] = 1'b1;
        scan_acc = clip32(64'(scan_acc) + q_mul(64'(h), e.out_coeff));
        r.chan = e.channel;
        r.val  = scan_acc;
        r.sat  = scan_sat;
        return (int'(e.state_index) == n - 1);
    endfunction

    task automatic send_word(sss_pkg::t_elem e, bit typed,
                             logic signed [sss_pkg::Q_W-1:0] tv, logic ts);
        t_scan_out r;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, e.skip_weight, e.input_u, e.out_coeff, e.drive,
                          e.decay, e.state_index, e.channel};
        s_axis_tuser  <= e.fresh_start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
        if (scan_word(e, r)) begin
            if (typed) begin
                r.val = tv;
                r.sat = ts;
            end
            scan_due.push_back(r);
        end
    endtask

    task automatic drain();
        // drop valid first so the last word is not taken again
        s_axis_tvalid <= 1'b0;
        while (scan_due.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_count(logic [4:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        state_cnt = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [sss_pkg::Q_W-1:0] rand_q();
        if ($urandom_range(0, 7) == 0) return $urandom;
        return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endfunction

    function automatic sss_pkg::t_elem rand_word(int ch, int st);
        sss_pkg::t_elem e;
        e.channel     = ch;
        e.state_index = st;
        e.decay       = ($urandom_range(0, 7) == 0) ? $urandom
                        : $signed($urandom_range(0, 3 << 16)) - (3 << 15);
        e.drive       = rand_q();
        e.out_coeff   = rand_q();
        e.input_u     = rand_q();
        e.skip_weight = rand_q();
        // never read a hidden entry that was not written
        e.fresh_start = !hidden_set[ch * N_ST + st] || $urandom_range(0, 9) == 0;
        return e;
    endfunction

    function automatic t_row row(logic fr, int ch, int st, logic [31:0] dc, logic [31:0] dv,
                                 logic [31:0] co, logic [31:0] u, logic [31:0] sk,
                                 logic typed, logic [31:0] v, logic s);
        t_row r;
        r.item  = '{channel: ch, state_index: st, fresh_start: fr, decay: dc, drive: dv,
                    out_coeff: co, input_u: u, skip_weight: sk};
        r.typed = typed;
        r.val   = v;
        r.sat   = s;
        return r;
    endfunction

    // output checker
    always @(posedge i_clk) begin
        t_scan_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (scan_due.size() == 0) begin
                $display("%0t: unexpected word ch=%0d val=%h sat=%0d", $time,
                         m_axis_tdata[9:0], m_axis_tdata[41:10], m_axis_tuser[0]);
                fail_count++;
            end else begin
                want = scan_due.pop_front();
                words_checked++;
                if (m_axis_tdata[9:0] !== want.chan) begin
                    $display("%0t: channel expected %0d actual %0d", $time,
                             want.chan, m_axis_tdata[9:0]);
                    fail_count++;
                end
                if (m_axis_tdata[41:10] !== want.val) begin
                    $display("%0t: scan value expected %h actual %h", $time,
                             want.val, m_axis_tdata[41:10]);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== want.sat) begin
                    $display("%0t: saturated expected %0d actual %0d", $time,
                             want.sat, m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tdata[47:42] !== 6'd0) begin
                    $display("%0t: fill expected 0 actual %h", $time, m_axis_tdata[47:42]);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        logic rdy;
        rdy = 1'b1;
        if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            rdy = 1'b0;
        end
        m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        t_row        rows[$];
        logic [4:0]  counts[6];
        int          n;
        int          ch;
        int          phase_start;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        stall_left    = 0;
        calm          = 0;
        fail_count    = 0;
        words_sent    = 0;
        words_checked = 0;
        cycle_count   = 0;
        scan_acc      = '0;
        scan_sat      = 1'b0;
        state_cnt     = 5'd16;
        foreach (hidden_set[i]) hidden_set[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, one state per channel
        rows.push_back(row(1, 0, 0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h10000,
                           1, 32'h30000, 0));
        rows.push_back(row(1, 1023, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           1, 32'h7FFFFFFF, 1));
        rows.push_back(row(1, 5, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF,
                           1, 32'h80000000, 1));
        // floor of a tiny negative product
        rows.push_back(row(1, 2, 0, 0, 32'hFFFFFFFF, 32'h1, 0, 0, 1, 32'hFFFFFFFF, 0));
        rows.push_back(row(1, 7, 0, 0, 32'h80000000, 32'h80000000, 0, 0,
                           1, 32'h7FFFFFFF, 1));
        rows.push_back(row(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                           32'h80000000, 32'h80000000, 0, 0, 0));
        rows.push_back(row(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0));
        // past the count: no word out
        rows.push_back(row(1, 3, 15, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0,
                           0, 0, 0));
        rows.push_back(row(0, 3, 15, 32'hFFFF8000, 32'h00018000, 32'h00020000,
                           32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0));
        rows.push_back(row(0, 2, 0, 32'h00010000, 32'h00000001, 32'hFFFF0000,
                           32'h00008000, 32'hFFFF8000, 0, 0, 0));
        write_count(5'd1);
        foreach (rows[i]) send_word(rows[i].item, rows[i].typed, rows[i].val, rows[i].sat);
        drain();

        counts = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd1, 5'($urandom_range(2, 15))};
        foreach (counts[p]) begin
            write_count(counts[p]);
            n = (state_cnt == 0) ? 1 : (state_cnt > N_ST) ? N_ST : state_cnt;
            phase_start = words_sent;
            while (words_sent - phase_start < RAND_ITEMS / 6) begin
                calm = (p == 5) && (words_sent - phase_start > RAND_ITEMS / 12);
                if ($urandom_range(0, 6) == 0) begin
                    send_word(rand_word($urandom_range(0, N_CH - 1),
                                        $urandom_range(0, N_ST - 1)), 0, 0, 0);
                end else begin
                    ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, N_CH - 1)
                                                     : $urandom_range(0, 7);
                    for (int s = 0; s < n; s++) send_word(rand_word(ch, s), 0, 0, 0);
                end
            end
            drain();
        end

        $display("%0d words sent, %0d output words checked, six state counts",
                 words_sent, words_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
